FILE: hdl/imasd_pkg.sv
// ----------------------------------------------------------------------------
// IMA ADPCM stream decoder package
// Shared types, constants and the step size table of the 4-bit decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package imasd_pkg;

  localparam int MAX_CHANNELS_DEF = 2;
  localparam int STEP_ENTRIES     = 89;
  localparam logic [6:0] IDX_MAX  = 7'd88;
  localparam logic [3:0] HDR_BYTES_CH = 4'd4;

  localparam logic [1:0] HDR_PRED_LO = 2'd0;
  localparam logic [1:0] HDR_PRED_HI = 2'd1;
  localparam logic [1:0] HDR_INDEX   = 2'd2;
  localparam logic [1:0] HDR_RSVD    = 2'd3;

  typedef logic signed [15:0] sample_t;
  typedef logic [6:0] step_idx_t;
  typedef logic [14:0] step_t;

  typedef struct packed {
    sample_t   pred;
    step_idx_t idx;
  } nib_state_t;

  localparam step_t STEP_TAB [STEP_ENTRIES] = '{
    15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
    15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
    15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
    15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
    15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
    15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
    15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
    15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
    15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
    15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
    15'd27086, 15'd29794, 15'd32767
  };

  function automatic step_t step_size(input step_idx_t idx);
    step_idx_t i;
    i = (idx > IDX_MAX) ? IDX_MAX : idx;
    return STEP_TAB[i];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/imasd_channels.sv
// ----------------------------------------------------------------------------
// IMA ADPCM stream decoder channels
// Valid/ready channels for input bytes, decoded samples and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface imasd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

interface imasd_sample_if;
  logic              valid;
  logic              ready;
  imasd_pkg::sample_t sample;
  logic              channel;
  logic              last_of_byte;
  modport source (output valid, output sample, output channel, output last_of_byte,
                  input ready);
  modport sink (input valid, input sample, input channel, input last_of_byte,
                output ready);
endinterface

interface imasd_cfg_if;
  logic valid;
  logic ready;
  logic stereo;
  modport source (output valid, output stereo, input ready);
  modport sink (input valid, input stereo, output ready);
endinterface

`default_nettype wire

FILE: hdl/ima_adpcm_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// IMA ADPCM stream decoder
// Parses channel headers and decodes 4-bit IMA ADPCM bytes into PCM samples.
// ----------------------------------------------------------------------------
// A header byte produces nothing; a data byte is decoded one nibble at a
// time, because a single nibble decoder and the one sample output register
// handle one sample per cycle unless the output stalls. A byte is held in
// an input register while its nibbles are decoded, and the output register
// lets the next byte transfer while a finished sample waits to be taken.
`default_nettype none

module ima_adpcm_stream_decoder_unit #(
  parameter int MAX_CHANNELS = imasd_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  imasd_byte_if.sink     in_ch,
  imasd_sample_if.source out_ch,
  imasd_cfg_if.sink      cfg_ch
);

  logic                 stereo_r;
  imasd_pkg::sample_t   pred_r [MAX_CHANNELS];
  imasd_pkg::step_idx_t idx_r [MAX_CHANNELS];
  logic [3:0]           hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]           lo_hold_r;

  logic       hold_vld_r, hold_vld_nxt;
  logic [7:0] hold_byte_r;
  logic       hold_first_r;
  logic       phase_r, phase_nxt;

  logic               out_vld_r, out_vld_nxt;
  imasd_pkg::sample_t out_sample_r;
  logic               out_chan_r;
  logic               out_last_r;

  logic       chans2;
  logic [3:0] hdr_len;
  logic [3:0] hc_eff;
  logic       is_hdr;
  logic       out_load;
  logic       do_data;
  logic       consume;
  logic       dec_ch;
  logic [3:0] dec_code;
  imasd_pkg::nib_state_t dec_cur, dec_upd;

  assign chans2   = stereo_r && (MAX_CHANNELS >= 2);
  assign hdr_len  = chans2 ? {imasd_pkg::HDR_BYTES_CH[2:0], 1'b0} : imasd_pkg::HDR_BYTES_CH;
  assign hc_eff   = hold_first_r ? 4'd0 : hdr_cnt_r;
  assign is_hdr   = !phase_r && (hc_eff < hdr_len);
  assign out_load = !out_vld_r || out_ch.ready;
  assign do_data  = hold_vld_r && !is_hdr && out_load;
  assign consume  = hold_vld_r && (is_hdr || (phase_r && out_load));
  assign dec_ch   = phase_r && chans2;
  assign dec_code = phase_r ? hold_byte_r[7:4] : hold_byte_r[3:0];

  assign dec_cur.pred = pred_r[dec_ch];
  assign dec_cur.idx  = idx_r[dec_ch];

  imasd_nibble_dec u_nib (
    .cur  (dec_cur),
    .code (dec_code),
    .upd  (dec_upd)
  );

  assign in_ch.ready  = !hold_vld_r || consume;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid        = out_vld_r;
  assign out_ch.sample       = out_sample_r;
  assign out_ch.channel      = out_chan_r;
  assign out_ch.last_of_byte = out_last_r;

  always_comb begin
    hold_vld_nxt = hold_vld_r;
    if (consume) hold_vld_nxt = 1'b0;
    if (in_ch.valid && in_ch.ready) hold_vld_nxt = 1'b1;
    phase_nxt = phase_r;
    if (do_data) phase_nxt = !phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    if (hold_vld_r && is_hdr) hdr_cnt_nxt = hc_eff + 4'd1;
    out_vld_nxt = out_vld_r;
    if (out_ch.ready) out_vld_nxt = 1'b0;
    if (do_data) out_vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stereo_r   <= 1'b0;
      hold_vld_r <= 1'b0;
      phase_r    <= 1'b0;
      out_vld_r  <= 1'b0;
      hdr_cnt_r  <= 4'd0;
      lo_hold_r  <= 8'd0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        pred_r[i] <= '0;
        idx_r[i]  <= '0;
      end
    end else begin
      hold_vld_r <= hold_vld_nxt;
      phase_r    <= phase_nxt;
      out_vld_r  <= out_vld_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      if (cfg_ch.valid && cfg_ch.ready) stereo_r <= cfg_ch.stereo;
      if (hold_vld_r && is_hdr && (int'(hc_eff[2]) < MAX_CHANNELS)) begin
        case (hc_eff[1:0])
          imasd_pkg::HDR_PRED_LO: lo_hold_r <= hold_byte_r;
          imasd_pkg::HDR_PRED_HI: pred_r[hc_eff[2]] <= {hold_byte_r, lo_hold_r};
          imasd_pkg::HDR_INDEX: begin
            idx_r[hc_eff[2]] <= (hold_byte_r > {1'b0, imasd_pkg::IDX_MAX}) ?
                                imasd_pkg::IDX_MAX : hold_byte_r[6:0];
          end
          imasd_pkg::HDR_RSVD: ;
          default: ;
        endcase
      end
      if (do_data) begin
        pred_r[dec_ch] <= dec_upd.pred;
        idx_r[dec_ch]  <= dec_upd.idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      hold_byte_r  <= in_ch.data_byte;
      hold_first_r <= in_ch.first_byte;
    end
    if (do_data) begin
      out_sample_r <= dec_upd.pred;
      out_chan_r   <= dec_ch;
      out_last_r   <= phase_r;
    end
  end

  a_phase_needs_byte : assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> hold_vld_r)
    else $error("second nibble pending without a held byte");

  a_first_sample_left : assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_last_r) |-> !out_chan_r)
    else $error("first sample of a byte not on channel zero");

  a_hdr_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    hdr_cnt_r <= {imasd_pkg::HDR_BYTES_CH[2:0], 1'b0})
    else $error("header count beyond two headers");

  a_idx_bound : assert property (@(posedge clk) disable iff (!rst_n)
    idx_r[0] <= imasd_pkg::IDX_MAX)
    else $error("step index above table range");

  a_sample_held : assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ch.ready) |=> (out_vld_r && $stable(out_sample_r)))
    else $error("stalled sample changed");

endmodule

`default_nettype wire

FILE: hdl/imasd_nibble_dec.sv
// ----------------------------------------------------------------------------
// IMA ADPCM nibble decoder
// Decodes one 4-bit code against a channel's predictor and step index.
// ----------------------------------------------------------------------------
`default_nettype none

module imasd_nibble_dec (
  input  imasd_pkg::nib_state_t cur,
  input  logic [3:0]            code,
  output imasd_pkg::nib_state_t upd
);

  localparam logic signed [17:0] PRED_MIN = -18'sd32768;
  localparam logic signed [17:0] PRED_MAX = 18'sd32767;
  localparam logic signed [7:0]  NI_MAX   = 8'sd88;

  imasd_pkg::step_t  step;
  logic [16:0]       diff;
  logic signed [17:0] p_ext;
  logic signed [17:0] p_sum;
  logic signed [7:0] adj;
  logic signed [7:0] ni;

  always_comb begin
    step  = imasd_pkg::step_size(cur.idx);
    diff  = {5'd0, step[14:3]}
          + (code[2] ? {2'd0, step} : 17'd0)
          + (code[1] ? {3'd0, step[14:1]} : 17'd0)
          + (code[0] ? {4'd0, step[14:2]} : 17'd0);
    p_ext = {{2{cur.pred[15]}}, cur.pred};
    if (code[3]) begin
      p_sum = p_ext - $signed({1'b0, diff});
      if (p_sum < PRED_MIN) p_sum = PRED_MIN;
    end else begin
      p_sum = p_ext + $signed({1'b0, diff});
      if (p_sum > PRED_MAX) p_sum = PRED_MAX;
    end
    upd.pred = p_sum[15:0];

    adj = code[2] ? $signed({5'd0, code[1:0], 1'b0} + 8'd2) : -8'sd1;
    ni  = $signed({1'b0, cur.idx}) + adj;
    if (ni < 8'sd0) ni = 8'sd0;
    if (ni > NI_MAX) ni = NI_MAX;
    upd.idx = ni[6:0];
  end

endmodule

`default_nettype wire
